// ----- hdl/mpsm_pkg.sv -----
// mpsm_pkg: shared sizes, codes, state encoding and helper functions
// for the multi-pattern string matcher
// depends on nothing
package mpsm_pkg;

	localparam int NODES           = 1024;
	localparam int NODE_W          = $clog2(NODES);
	localparam int CNT_W           = NODE_W + 1;
	localparam int ALPHABET        = 63;
	localparam int SYM_W           = 6;
	localparam int TT_DEPTH        = NODES * ALPHABET;
	localparam int TT_AW           = $clog2(TT_DEPTH);
	localparam int MAX_PATTERNS    = 256;
	localparam int PAT_W           = $clog2(MAX_PATTERNS + 1);
	localparam int MAX_PATTERN_LEN = 32;
	localparam int DEPTH_W         = $clog2(MAX_PATTERN_LEN + 1);
	localparam int MAX_RESULTS     = 32;
	localparam int NRES_W          = $clog2(MAX_RESULTS + 1);
	localparam int POS_W           = 16;

	typedef enum logic [1:0] {
		OP_PATTERN = 2'd0,
		OP_BUILD   = 2'd1,
		OP_DOC     = 2'd2,
		OP_NONE    = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		KIND_MATCH     = 2'd0,
		KIND_BUILT     = 2'd1,
		KIND_FULL      = 2'd2,
		KIND_OVERFLOW  = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_P_CHK,
		ST_P_UPD,
		ST_P_FIN,
		ST_B_SCAN,
		ST_B_DEQ,
		ST_B_FL,
		ST_B_ROW,
		ST_B_DONE,
		ST_D_STEP,
		ST_D_LOAD,
		ST_D_RD,
		ST_D_CHK
	} state_t;

	// byte to symbol: digits, lower case, upper case, everything else
	function automatic logic [SYM_W-1:0] symbol_of(input logic [7:0] b);
		logic [7:0] d;
		d = 8'd62;
		if (b >= 8'h30 && b <= 8'h39) d = b - 8'h30;
		else if (b >= 8'h61 && b <= 8'h7a) d = b - 8'h61 + 8'd10;
		else if (b >= 8'h41 && b <= 8'h5a) d = b - 8'h41 + 8'd36;
		return d[SYM_W-1:0];
	endfunction

	// transition table address of one node row and symbol
	function automatic logic [TT_AW-1:0] cell_addr(input logic [NODE_W-1:0] node,
			input logic [SYM_W-1:0] sym);
		return TT_AW'(node) * TT_AW'(ALPHABET) + TT_AW'(sym);
	endfunction

endpackage

// ----- hdl/multi_pattern_string_matcher.sv -----
// multi_pattern_string_matcher: trie build, failure-link pass and document
// scan over block memories, with one output register
// depends on mpsm_pkg
//
// after reset a clearing pass zeroes all 64512 transition table cells
// with in_stall high; control state clears at once
// pattern character: P_CHK, P_UPD and P_FIN, P_UPD skipped once discarded,
// dropped in idle after build; document character: D_STEP, D_LOAD, then
// D_RD and D_CHK per failure-chain node; a stalled output adds its wait
// build: one table cell per cycle in B_SCAN; B_DEQ, B_FL, B_ROW fetch the next node
module multi_pattern_string_matcher (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] opcode,
	input  logic [7:0] char_byte,
	input  logic       first_char,
	input  logic       last_char,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] pattern_id,
	output logic [15:0] position,
	output logic       last_result
);

	localparam int NW = mpsm_pkg::NODE_W;
	localparam int AW = mpsm_pkg::TT_AW;
	localparam int SW = mpsm_pkg::SYM_W;

	mpsm_pkg::state_t state_q, state_d;

	// captured item
	logic [SW-1:0] sym_q;
	logic          lastc_q;

	// insertion and scan state
	logic [NW-1:0]                   ins_node_q;
	logic [mpsm_pkg::DEPTH_W-1:0]    ins_depth_q;
	logic                            discard_q;
	logic [mpsm_pkg::CNT_W-1:0]      node_cnt_q;
	logic [mpsm_pkg::PAT_W-1:0]      pat_cnt_q;
	logic                            built_q;
	logic [NW-1:0]                   match_q;
	logic [mpsm_pkg::POS_W-1:0]      docpos_q;
	logic [mpsm_pkg::POS_W-1:0]      curpos_q;
	logic [NW-1:0]                   walk_q;
	logic [mpsm_pkg::NRES_W-1:0]     nres_q;
	logic                            pend_v_q;
	logic [7:0]                      pend_id_q;

	// build state
	logic [NW-1:0]  u_q, f_q;
	logic           root_q;
	logic [SW-1:0]  bi_q, bi_s1;
	logic           bv_s1;
	logic [NW:0]    head_q, tail_q;
	logic [AW-1:0]  clr_q;

	// memories
	logic [NW-1:0] tt_mem [mpsm_pkg::TT_DEPTH];
	logic [NW-1:0] fl_mem [mpsm_pkg::NODES];
	logic [mpsm_pkg::PAT_W-1:0] tp_mem [mpsm_pkg::NODES];
	logic [NW-1:0] q_mem  [mpsm_pkg::NODES];

	logic          tt_we, tt_rea, tt_reb;
	logic [AW-1:0] tt_wa, tt_raa, tt_rab;
	logic [NW-1:0] tt_wd, tt_rda, tt_rdb;
	logic          fl_we, fl_re;
	logic [NW-1:0] fl_wa, fl_wd, fl_ra, fl_rd;
	logic          tp_we, tp_re;
	logic [NW-1:0] tp_wa, tp_ra;
	logic [mpsm_pkg::PAT_W-1:0] tp_wd, tp_rd;
	logic          q_we, q_re;
	logic [NW-1:0] q_wa, q_wd, q_ra, q_rd;

	// emit request into the output register
	logic        emit;
	logic [1:0]  emit_kind;
	logic [7:0]  emit_id;
	logic [15:0] emit_pos;
	logic        emit_last;

	logic out_free, accept;
	logic table_full, too_long, scan_end;
	logic [NW-1:0] new_node;

	assign out_free   = !out_valid || !out_stall;
	assign in_stall   = (state_q != mpsm_pkg::ST_IDLE);
	assign accept     = in_valid && !in_stall;
	assign table_full = (node_cnt_q >= mpsm_pkg::CNT_W'(mpsm_pkg::NODES));
	assign too_long   = (ins_depth_q >= mpsm_pkg::DEPTH_W'(mpsm_pkg::MAX_PATTERN_LEN));
	assign new_node   = node_cnt_q[NW-1:0];
	assign scan_end   = (walk_q == '0) || (nres_q == mpsm_pkg::NRES_W'(mpsm_pkg::MAX_RESULTS));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mpsm_pkg::ST_CLEAR: begin
				if (clr_q == AW'(mpsm_pkg::TT_DEPTH - 1)) state_d = mpsm_pkg::ST_IDLE;
			end
			mpsm_pkg::ST_IDLE: begin
				if (accept) begin
					case (opcode)
						mpsm_pkg::OP_PATTERN: if (!built_q) state_d = mpsm_pkg::ST_P_CHK;
						mpsm_pkg::OP_BUILD:
							state_d = built_q ? mpsm_pkg::ST_B_DONE : mpsm_pkg::ST_B_SCAN;
						mpsm_pkg::OP_DOC: state_d = mpsm_pkg::ST_D_STEP;
						default: state_d = mpsm_pkg::ST_IDLE;
					endcase
				end
			end
			mpsm_pkg::ST_P_CHK: begin
				if (discard_q) state_d = mpsm_pkg::ST_P_FIN;
				else if (too_long) begin
					if (out_free) state_d = mpsm_pkg::ST_P_FIN;
				end else state_d = mpsm_pkg::ST_P_UPD;
			end
			mpsm_pkg::ST_P_UPD: begin
				if (!(tt_rda == '0 && table_full && !out_free)) state_d = mpsm_pkg::ST_P_FIN;
			end
			mpsm_pkg::ST_P_FIN: begin
				if (!(lastc_q && !discard_q && ins_node_q != '0 &&
						pat_cnt_q >= mpsm_pkg::PAT_W'(mpsm_pkg::MAX_PATTERNS) && !out_free))
					state_d = mpsm_pkg::ST_IDLE;
			end
			mpsm_pkg::ST_B_SCAN: begin
				if (bi_q == SW'(mpsm_pkg::ALPHABET) && !bv_s1) state_d = mpsm_pkg::ST_B_DEQ;
			end
			mpsm_pkg::ST_B_DEQ:
				state_d = (head_q == tail_q) ? mpsm_pkg::ST_B_DONE : mpsm_pkg::ST_B_FL;
			mpsm_pkg::ST_B_FL:  state_d = mpsm_pkg::ST_B_ROW;
			mpsm_pkg::ST_B_ROW: state_d = mpsm_pkg::ST_B_SCAN;
			mpsm_pkg::ST_B_DONE: begin
				if (out_free) state_d = mpsm_pkg::ST_IDLE;
			end
			mpsm_pkg::ST_D_STEP: state_d = mpsm_pkg::ST_D_LOAD;
			mpsm_pkg::ST_D_LOAD: state_d = mpsm_pkg::ST_D_RD;
			mpsm_pkg::ST_D_RD: begin
				if (scan_end) begin
					if (!pend_v_q || out_free) state_d = mpsm_pkg::ST_IDLE;
				end else state_d = mpsm_pkg::ST_D_CHK;
			end
			mpsm_pkg::ST_D_CHK: begin
				if (!(tp_rd != '0 && pend_v_q && !out_free)) state_d = mpsm_pkg::ST_D_RD;
			end
			default: state_d = mpsm_pkg::ST_IDLE;
		endcase
	end

	// memory controls and result requests
	always_comb begin
		tt_we = 1'b0; tt_wa = '0; tt_wd = '0;
		tt_rea = 1'b0; tt_raa = '0; tt_reb = 1'b0; tt_rab = '0;
		fl_we = 1'b0; fl_wa = '0; fl_wd = '0; fl_re = 1'b0; fl_ra = '0;
		tp_we = 1'b0; tp_wa = '0; tp_wd = '0; tp_re = 1'b0; tp_ra = '0;
		q_we = 1'b0; q_wa = '0; q_wd = '0; q_re = 1'b0; q_ra = '0;
		emit = 1'b0; emit_kind = mpsm_pkg::KIND_MATCH; emit_id = '0;
		emit_pos = '0; emit_last = 1'b1;
		unique case (state_q)
			mpsm_pkg::ST_CLEAR: begin
				tt_we = 1'b1;
				tt_wa = clr_q;
			end
			mpsm_pkg::ST_P_CHK: begin
				if (!discard_q && too_long) begin
					emit = out_free;
					emit_kind = mpsm_pkg::KIND_OVERFLOW;
				end else if (!discard_q) begin
					tt_rea = 1'b1;
					tt_raa = mpsm_pkg::cell_addr(ins_node_q, sym_q);
				end
			end
			mpsm_pkg::ST_P_UPD: begin
				if (tt_rda == '0 && table_full) begin
					emit = out_free;
					emit_kind = mpsm_pkg::KIND_FULL;
				end else if (tt_rda == '0) begin
					tt_we = 1'b1;
					tt_wa = mpsm_pkg::cell_addr(ins_node_q, sym_q);
					tt_wd = new_node;
					fl_we = 1'b1;
					fl_wa = new_node;
					tp_we = 1'b1;
					tp_wa = new_node;
				end
			end
			mpsm_pkg::ST_P_FIN: begin
				if (lastc_q && !discard_q && ins_node_q != '0) begin
					if (pat_cnt_q >= mpsm_pkg::PAT_W'(mpsm_pkg::MAX_PATTERNS)) begin
						emit = out_free;
						emit_kind = mpsm_pkg::KIND_OVERFLOW;
					end else begin
						tp_we = 1'b1;
						tp_wa = ins_node_q;
						tp_wd = pat_cnt_q + 1'b1;
					end
				end
			end
			mpsm_pkg::ST_B_SCAN: begin
				// issue reads of own row and failure row
				if (bi_q != SW'(mpsm_pkg::ALPHABET)) begin
					tt_rea = 1'b1;
					tt_raa = mpsm_pkg::cell_addr(u_q, bi_q);
					tt_reb = 1'b1;
					tt_rab = mpsm_pkg::cell_addr(f_q, bi_q);
				end
				// finish one cell: child gets failure link, hole of a non-root row gets failure edge
				if (bv_s1) begin
					if (tt_rda != '0) begin
						fl_we = 1'b1;
						fl_wa = tt_rda;
						fl_wd = root_q ? '0 : tt_rdb;
						if (tail_q < (NW+1)'(mpsm_pkg::NODES)) begin
							q_we = 1'b1;
							q_wa = tail_q[NW-1:0];
							q_wd = tt_rda;
						end
					end else if (!root_q) begin
						tt_we = 1'b1;
						tt_wa = mpsm_pkg::cell_addr(u_q, bi_s1);
						tt_wd = tt_rdb;
					end
				end
			end
			mpsm_pkg::ST_B_DEQ: begin
				if (head_q != tail_q) begin
					q_re = 1'b1;
					q_ra = head_q[NW-1:0];
				end
			end
			mpsm_pkg::ST_B_FL: begin
				fl_re = 1'b1;
				fl_ra = q_rd;
			end
			mpsm_pkg::ST_B_DONE: begin
				emit = out_free;
				emit_kind = mpsm_pkg::KIND_BUILT;
			end
			mpsm_pkg::ST_D_STEP: begin
				tt_rea = 1'b1;
				tt_raa = mpsm_pkg::cell_addr(match_q, sym_q);
			end
			mpsm_pkg::ST_D_RD: begin
				if (scan_end) begin
					emit = pend_v_q && out_free;
					emit_id = pend_id_q;
					emit_pos = curpos_q;
				end else begin
					tp_re = 1'b1;
					tp_ra = walk_q;
					fl_re = 1'b1;
					fl_ra = walk_q;
				end
			end
			mpsm_pkg::ST_D_CHK: begin
				// a new match releases the held one as not last
				if (tp_rd != '0 && pend_v_q) begin
					emit = out_free;
					emit_id = pend_id_q;
					emit_pos = curpos_q;
					emit_last = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	// transition table, two read ports
	always_ff @(posedge clk) begin
		if (tt_we) tt_mem[tt_wa] <= tt_wd;
		if (tt_rea) tt_rda <= tt_mem[tt_raa];
		if (tt_reb) tt_rdb <= tt_mem[tt_rab];
	end

	// failure links
	always_ff @(posedge clk) begin
		if (fl_we) fl_mem[fl_wa] <= fl_wd;
		if (fl_re) fl_rd <= fl_mem[fl_ra];
	end

	// terminal pattern numbers plus one
	always_ff @(posedge clk) begin
		if (tp_we) tp_mem[tp_wa] <= tp_wd;
		if (tp_re) tp_rd <= tp_mem[tp_ra];
	end

	// breadth-first queue
	always_ff @(posedge clk) begin
		if (q_we) q_mem[q_wa] <= q_wd;
		if (q_re) q_rd <= q_mem[q_ra];
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mpsm_pkg::ST_CLEAR;
			clr_q       <= '0;
			ins_node_q  <= '0;
			ins_depth_q <= '0;
			discard_q   <= 1'b0;
			node_cnt_q  <= mpsm_pkg::CNT_W'(1);
			pat_cnt_q   <= '0;
			built_q     <= 1'b0;
			match_q     <= '0;
			docpos_q    <= '0;
			pend_v_q    <= 1'b0;
			nres_q      <= '0;
			bv_s1       <= 1'b0;
			head_q      <= '0;
			tail_q      <= '0;
		end else begin
			state_q <= state_d;
			bv_s1   <= (state_q == mpsm_pkg::ST_B_SCAN) && (bi_q != SW'(mpsm_pkg::ALPHABET));
			case (state_q)
				mpsm_pkg::ST_CLEAR: clr_q <= clr_q + 1'b1;
				mpsm_pkg::ST_IDLE: begin
					if (accept) begin
						if (opcode == mpsm_pkg::OP_PATTERN && !built_q && first_char) begin
							ins_node_q  <= '0;
							ins_depth_q <= '0;
							discard_q   <= 1'b0;
						end
						if (opcode == mpsm_pkg::OP_BUILD) begin
							head_q <= '0;
							tail_q <= '0;
						end
						if (opcode == mpsm_pkg::OP_DOC) begin
							if (first_char) begin
								match_q  <= '0;
								docpos_q <= 16'd1;
							end else if (docpos_q != 16'hffff) docpos_q <= docpos_q + 1'b1;
						end
					end
				end
				mpsm_pkg::ST_P_CHK: begin
					if (!discard_q && too_long && out_free) discard_q <= 1'b1;
				end
				mpsm_pkg::ST_P_UPD: begin
					if (tt_rda == '0 && table_full) begin
						if (out_free) discard_q <= 1'b1;
					end else begin
						if (tt_rda == '0) node_cnt_q <= node_cnt_q + 1'b1;
						ins_node_q  <= (tt_rda == '0) ? new_node : tt_rda;
						ins_depth_q <= ins_depth_q + 1'b1;
					end
				end
				mpsm_pkg::ST_P_FIN: begin
					if (lastc_q && state_d == mpsm_pkg::ST_IDLE) begin
						if (!discard_q && ins_node_q != '0 &&
								pat_cnt_q < mpsm_pkg::PAT_W'(mpsm_pkg::MAX_PATTERNS))
							pat_cnt_q <= pat_cnt_q + 1'b1;
						ins_node_q  <= '0;
						ins_depth_q <= '0;
						discard_q   <= 1'b0;
					end
				end
				mpsm_pkg::ST_B_SCAN: begin
					if (q_we) tail_q <= tail_q + 1'b1;
				end
				mpsm_pkg::ST_B_DEQ: begin
					if (head_q != tail_q) head_q <= head_q + 1'b1;
				end
				mpsm_pkg::ST_B_DONE: begin
					if (out_free) built_q <= 1'b1;
				end
				mpsm_pkg::ST_D_LOAD: begin
					match_q  <= tt_rda;
					nres_q   <= '0;
					pend_v_q <= 1'b0;
				end
				mpsm_pkg::ST_D_RD: begin
					if (scan_end && emit) pend_v_q <= 1'b0;
				end
				mpsm_pkg::ST_D_CHK: begin
					if (tp_rd != '0 && (!pend_v_q || out_free)) begin
						pend_v_q <= 1'b1;
						nres_q   <= nres_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers of the sequencer
	always_ff @(posedge clk) begin
		if (accept) begin
			sym_q   <= mpsm_pkg::symbol_of(char_byte);
			lastc_q <= last_char;
			if (opcode == mpsm_pkg::OP_DOC) curpos_q <= first_char ? '0 : docpos_q;
			if (opcode == mpsm_pkg::OP_BUILD) begin
				u_q    <= '0;
				f_q    <= '0;
				root_q <= 1'b1;
				bi_q   <= '0;
			end
		end
		if (state_q == mpsm_pkg::ST_B_SCAN && bi_q != SW'(mpsm_pkg::ALPHABET))
			bi_q <= bi_q + 1'b1;
		bi_s1 <= bi_q;
		if (state_q == mpsm_pkg::ST_B_FL) u_q <= q_rd;
		if (state_q == mpsm_pkg::ST_B_ROW) begin
			f_q    <= fl_rd;
			root_q <= 1'b0;
			bi_q   <= '0;
		end
		if (state_q == mpsm_pkg::ST_D_LOAD) walk_q <= tt_rda;
		if (state_q == mpsm_pkg::ST_D_CHK && state_d == mpsm_pkg::ST_D_RD) begin
			walk_q <= fl_rd;
			if (tp_rd != '0) pend_id_q <= 8'(tp_rd - 1'b1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (emit) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind        <= emit_kind;
			pattern_id  <= emit_id;
			position    <= emit_pos;
			last_result <= emit_last;
		end
	end

	// checks
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!out_valid || !out_stall))
		else $error("result written over a waiting result");

	a_node_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		node_cnt_q <= mpsm_pkg::CNT_W'(mpsm_pkg::NODES))
		else $error("node count beyond table");

	a_queue_order: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q)
		else $error("queue head passed tail");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		ins_depth_q <= mpsm_pkg::DEPTH_W'(mpsm_pkg::MAX_PATTERN_LEN))
		else $error("insert depth beyond pattern limit");

	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != mpsm_pkg::ST_CLEAR |=> state_q != mpsm_pkg::ST_CLEAR)
		else $error("clearing pass restarted");

endmodule
